>>> rtl/core/drip_rate_stall_monitor_defines.svh
// Assertion macros used by the monitor top level.
`ifndef DRIP_RATE_STALL_MONITOR_DEFINES_SVH
`define DRIP_RATE_STALL_MONITOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DRSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("drsm: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DRSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("drsm: next-cycle check failed");

`endif

>>> rtl/core/drsm_pkg.sv
// Shared constants, codes and types for the drip-rate and stall monitor.
package drsm_pkg;

    localparam int TIME_W  = 32;
    localparam int GAP_W   = 16;
    localparam int MINR_W  = 8;
    localparam int RATE_W  = 16;
    localparam int DROPS_W = 24;
    localparam int STATE_W = 2;
    localparam int MSG_W   = 16;
    localparam int KIND_W  = 2;
    localparam int CFGA_W  = 2;
    localparam int CFGD_W  = 16;
    localparam int OUT_W   = 80;

    // Bit-serial divider: one quotient bit per cycle
    localparam int DIV_W     = RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [RATE_W-1:0] MINUTE_MS = 16'd60000;

    localparam logic [GAP_W-1:0]  DROP_GAP_RST = 16'd200;
    localparam logic [GAP_W-1:0]  STALL_RST    = 16'd5000;
    localparam logic [MINR_W-1:0] MIN_REP_RST  = 8'd1;

    // Request kinds
    localparam logic [KIND_W-1:0] REQ_DROP   = 2'd0;
    localparam logic [KIND_W-1:0] REQ_CHECK  = 2'd1;
    localparam logic [KIND_W-1:0] REQ_REPORT = 2'd2;
    localparam logic [KIND_W-1:0] REQ_PRESS  = 2'd3;

    // Monitor status
    localparam logic [STATE_W-1:0] ST_IDLE    = 2'd0;
    localparam logic [STATE_W-1:0] ST_RUN     = 2'd1;
    localparam logic [STATE_W-1:0] ST_BLOCKED = 2'd2;

    // Configuration register indexes
    localparam logic [CFGA_W-1:0] CFG_DROP_GAP = 2'd0;
    localparam logic [CFGA_W-1:0] CFG_STALL    = 2'd1;
    localparam logic [CFGA_W-1:0] CFG_MIN_REP  = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/core/drsm_div.sv
// Restoring bit-serial divider: 16-bit dividend over a 32-bit divisor.
module drsm_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [drsm_pkg::DIV_W-1:0]         dividend,
    input  logic [drsm_pkg::TIME_W-1:0]        divisor,
    output drsm_pkg::div_stat_t                stat,
    output logic [drsm_pkg::DIV_W-1:0]         quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [drsm_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [drsm_pkg::DIV_W-1:0]      quot_reg, quot_next;
    logic [drsm_pkg::DIV_W-1:0]      rem_reg, rem_next;
    logic [drsm_pkg::TIME_W-1:0]     dvs_reg, dvs_next;
    logic [drsm_pkg::DIV_W:0]        trial;
    logic [drsm_pkg::TIME_W-1:0]     trial_ext;
    logic [drsm_pkg::TIME_W-1:0]     diff;
    logic                            fits;

    assign trial     = {rem_reg, quot_reg[drsm_pkg::DIV_W-1]};
    assign trial_ext = {{(drsm_pkg::TIME_W-drsm_pkg::DIV_W-1){1'b0}}, trial};
    assign fits      = trial_ext >= dvs_reg;
    assign diff      = trial_ext - dvs_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = drsm_pkg::DIV_CNT_W'(drsm_pkg::DIV_W - 1);
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // remainder never exceeds the dividend, so 16 bits hold it
            rem_next  = fits ? diff[drsm_pkg::DIV_W-1:0] : trial[drsm_pkg::DIV_W-1:0];
            quot_next = {quot_reg[drsm_pkg::DIV_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule

>>> rtl/core/drip_rate_stall_monitor.sv
// Top level: event sequencer, monitor state and result register.
// Drip-rate and stall monitor.
// Input channel s_*: one transaction per event; s_tuser is the request kind
// (drop, time check, report tick, start/stop press), s_tdata the ms timestamp.
// Result channel m_*: exactly one transaction per input event, carrying the
// rate, drop total, monitor status, target rate, message total and the
// alarm/report/drop flags for that event.
// Config channel cfg_*: always ready; index 0 drop gap, 1 stall time,
// 2 minimum reports, other indexes ignored. Write only while idle.
// Sequencing: an accepted event is evaluated and then written to the result
// register; an accepted drop first waits for the bit-serial divider computing
// 60000/interval at one quotient bit per cycle (16 steps). s_tready is high only
// while the sequencer is idle, so a new event enters in the cycle after the
// previous result has moved into the output register.
// Stall: the result register holds while m_tready is low; the next event is
// still accepted and waits finished until the register frees up.
// Reset (aresetn low, synchronous): registers take their defaults, status
// idle, counters and rates zero, stall detection armed, output empty.
module drip_rate_stall_monitor (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input events
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [drsm_pkg::TIME_W-1:0]       s_tdata,  // [31:0] time_ms
    input  logic [drsm_pkg::KIND_W-1:0]       s_tuser,  // [1:0] req_type
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] drop_rate, [39:16] drop_total, [41:40] mon_state,
    // [57:42] target_rate, [73:58] msg_total, [74] block_alarm,
    // [75] report_due, [76] drop_taken, [79:77] zero
    output logic [drsm_pkg::OUT_W-1:0]        m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [drsm_pkg::CFGA_W-1:0]       cfg_addr,
    input  logic [drsm_pkg::CFGD_W-1:0]       cfg_data
);

    `include "drip_rate_stall_monitor_defines.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                        state_reg, state_next;
    logic [drsm_pkg::GAP_W-1:0]        gap_reg, stall_reg;
    logic [drsm_pkg::MINR_W-1:0]       minrep_reg;

    logic [drsm_pkg::KIND_W-1:0]       kind_reg;
    logic [drsm_pkg::TIME_W-1:0]       time_reg;

    logic [drsm_pkg::TIME_W-1:0]       last_drop_reg, last_drop_next;
    logic [drsm_pkg::RATE_W-1:0]       rate_reg, rate_next;
    logic [drsm_pkg::DROPS_W-1:0]      drop_cnt_reg, drop_cnt_next;
    logic [drsm_pkg::STATE_W-1:0]      status_reg, status_next;
    logic [drsm_pkg::RATE_W-1:0]       target_reg, target_next;
    logic [drsm_pkg::MSG_W-1:0]        msg_reg, msg_next;
    logic                              armed_reg, armed_next;
    logic                              alarm_reg, alarm_next;
    logic                              report_reg, report_next;
    logic                              taken_reg, taken_next;

    logic                              m_valid_reg, m_valid_next;
    logic [drsm_pkg::OUT_W-1:0]        m_data_reg, m_data_next;

    logic [drsm_pkg::TIME_W-1:0]       since;
    logic                              drop_ok;
    logic                              stall_hit;
    logic                              div_start;
    drsm_pkg::div_stat_t               div_stat;
    logic [drsm_pkg::DIV_W-1:0]        div_quot;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // interval since last accepted drop, modulo 2^32
    assign since   = time_reg - last_drop_reg;
    assign drop_ok = since > {{(drsm_pkg::TIME_W-drsm_pkg::GAP_W){1'b0}}, gap_reg};
    assign stall_hit = (since > {{(drsm_pkg::TIME_W-drsm_pkg::GAP_W){1'b0}}, stall_reg})
                       && armed_reg && (status_reg == drsm_pkg::ST_RUN)
                       && (msg_reg > {{(drsm_pkg::MSG_W-drsm_pkg::MINR_W){1'b0}}, minrep_reg});
    assign div_start = (state_reg == S_EVAL) && (kind_reg == drsm_pkg::REQ_DROP) && drop_ok;

    drsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (drsm_pkg::MINUTE_MS),
        .divisor  (since),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    always_comb begin
        state_next     = state_reg;
        last_drop_next = last_drop_reg;
        rate_next      = rate_reg;
        drop_cnt_next  = drop_cnt_reg;
        status_next    = status_reg;
        target_next    = target_reg;
        msg_next       = msg_reg;
        armed_next     = armed_reg;
        alarm_next     = alarm_reg;
        report_next    = report_reg;
        taken_next     = taken_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                alarm_next  = 1'b0;
                report_next = 1'b0;
                taken_next  = 1'b0;
                state_next  = S_DONE;
                unique case (kind_reg)
                    drsm_pkg::REQ_DROP: begin
                        if (drop_ok) begin
                            last_drop_next = time_reg;
                            if (drop_cnt_reg != '1) begin
                                drop_cnt_next = drop_cnt_reg + 1'b1;
                            end
                            if (status_reg == drsm_pkg::ST_BLOCKED) begin
                                status_next = drsm_pkg::ST_RUN;
                            end
                            armed_next = 1'b1;
                            taken_next = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    drsm_pkg::REQ_CHECK: begin
                        if (stall_hit) begin
                            status_next = drsm_pkg::ST_BLOCKED;
                            msg_next    = msg_reg + 1'b1;
                            armed_next  = 1'b0;
                            alarm_next  = 1'b1;
                        end else begin
                            armed_next = 1'b1;
                        end
                    end
                    drsm_pkg::REQ_REPORT: begin
                        if (status_reg == drsm_pkg::ST_RUN) begin
                            msg_next    = msg_reg + 1'b1;
                            report_next = 1'b1;
                        end
                    end
                    drsm_pkg::REQ_PRESS: begin
                        if (status_reg == drsm_pkg::ST_IDLE) begin
                            status_next = drsm_pkg::ST_RUN;
                            target_next = rate_reg;
                        end else begin
                            status_next = drsm_pkg::ST_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            S_DIV: begin
                if (div_stat.done) begin
                    rate_next  = div_quot;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, taken_reg, report_reg, alarm_reg, msg_reg,
                                    target_reg, status_reg, drop_cnt_reg, rate_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            gap_reg       <= drsm_pkg::DROP_GAP_RST;
            stall_reg     <= drsm_pkg::STALL_RST;
            minrep_reg    <= drsm_pkg::MIN_REP_RST;
            last_drop_reg <= '0;
            rate_reg      <= '0;
            drop_cnt_reg  <= '0;
            status_reg    <= drsm_pkg::ST_IDLE;
            target_reg    <= '0;
            msg_reg       <= '0;
            armed_reg     <= 1'b1;
            alarm_reg     <= 1'b0;
            report_reg    <= 1'b0;
            taken_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_drop_reg <= last_drop_next;
            rate_reg      <= rate_next;
            drop_cnt_reg  <= drop_cnt_next;
            status_reg    <= status_next;
            target_reg    <= target_next;
            msg_reg       <= msg_next;
            armed_reg     <= armed_next;
            alarm_reg     <= alarm_next;
            report_reg    <= report_next;
            taken_reg     <= taken_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_addr)
                    drsm_pkg::CFG_DROP_GAP: gap_reg    <= cfg_data;
                    drsm_pkg::CFG_STALL:    stall_reg  <= cfg_data;
                    drsm_pkg::CFG_MIN_REP:  minrep_reg <= cfg_data[drsm_pkg::MINR_W-1:0];
                    default: ;
                endcase
            end
        end
        if (s_tvalid && s_tready) begin
            kind_reg <= s_tuser;
            time_reg <= s_tdata;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `DRSM_ASSERT_NOW(a_div_busy_in_div, div_stat.busy, state_reg == S_DIV)
    `DRSM_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_reg == S_DIV)
    `DRSM_ASSERT_NOW(a_flags_exclusive, m_valid_reg, !(m_data_reg[74] && m_data_reg[76]))
    `DRSM_ASSERT_NEXT(a_drops_monotonic, 1'b1, drop_cnt_reg >= $past(drop_cnt_reg))

endmodule

>>> dv/testbench.sv
// Testbench for the drip-rate and stall monitor: event stimulus, status prediction and checking.
import drsm_pkg::*;

typedef struct {
    logic [RATE_W-1:0]  rate;
    logic [DROPS_W-1:0] drops;
    logic [STATE_W-1:0] status;
    logic [RATE_W-1:0]  target;
    logic [MSG_W-1:0]   msgs;
    logic               alarm;
    logic               report;
    logic               taken;
} drip_status_t;

class drip_status_tracker;
    logic [GAP_W-1:0]   drop_gap;
    logic [GAP_W-1:0]   stall_time;
    logic [MINR_W-1:0]  min_rep;
    logic [TIME_W-1:0]  last_drop;
    logic [RATE_W-1:0]  rate;
    logic [DROPS_W-1:0] drops;
    logic [STATE_W-1:0] status;
    logic [RATE_W-1:0]  target;
    logic [MSG_W-1:0]   msgs;
    bit                 armed;
    drip_status_t       due_status[$];
    int                 bad_status;

    function new();
        drop_gap   = DROP_GAP_RST;
        stall_time = STALL_RST;
        min_rep    = MIN_REP_RST;
        last_drop  = '0;
        rate       = '0;
        drops      = '0;
        status     = ST_IDLE;
        target     = '0;
        msgs       = '0;
        armed      = 1'b1;
        bad_status = 0;
    endfunction

    function void write_register(logic [CFGA_W-1:0] addr, logic [CFGD_W-1:0] data);
        case (addr)
            CFG_DROP_GAP: drop_gap = data;
            CFG_STALL:    stall_time = data;
            CFG_MIN_REP:  min_rep = data[MINR_W-1:0];
            default:      ;
        endcase
    endfunction

    function void take_event(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] since;
        drip_status_t st;
        since = now - last_drop;   // wraps modulo 2^32
        st.alarm  = 1'b0;
        st.report = 1'b0;
        st.taken  = 1'b0;
        case (kind)
            REQ_DROP: begin
                if (since > TIME_W'(drop_gap)) begin
                    rate = RATE_W'(TIME_W'(MINUTE_MS) / since);
                    last_drop = now;
                    if (drops != '1) drops++;
                    if (status == ST_BLOCKED) status = ST_RUN;
                    armed = 1'b1;
                    st.taken = 1'b1;
                end
            end
            REQ_CHECK: begin
                if (since > TIME_W'(stall_time) && armed && status == ST_RUN &&
                    msgs > MSG_W'(min_rep)) begin
                    status = ST_BLOCKED;
                    msgs++;
                    armed = 1'b0;
                    st.alarm = 1'b1;
                end else begin
                    armed = 1'b1;
                end
            end
            REQ_REPORT: begin
                if (status == ST_RUN) begin
                    msgs++;
                    st.report = 1'b1;
                end
            end
            REQ_PRESS: begin
                if (status == ST_IDLE) begin
                    status = ST_RUN;
                    target = rate;
                end else begin
                    status = ST_IDLE;
                end
            end
        endcase
        st.rate   = rate;
        st.drops  = drops;
        st.status = status;
        st.target = target;
        st.msgs   = msgs;
        due_status.push_back(st);
    endfunction

    function void match_status(logic [OUT_W-1:0] word);
        drip_status_t want;
        drip_status_t got;
        bit ok;
        got.rate   = word[15:0];
        got.drops  = word[39:16];
        got.status = word[41:40];
        got.target = word[57:42];
        got.msgs   = word[73:58];
        got.alarm  = word[74];
        got.report = word[75];
        got.taken  = word[76];
        if (due_status.size() == 0) begin
            bad_status++;
            if (bad_status <= 10) $display("result %h arrived with no event outstanding", word);
            return;
        end
        want = due_status.pop_front();
        ok = want.rate == got.rate && want.drops == got.drops &&
             want.status == got.status && want.target == got.target &&
             want.msgs == got.msgs && want.alarm == got.alarm &&
             want.report == got.report && want.taken == got.taken && word[79:77] == 3'b000;
        if (!ok) begin
            bad_status++;
            if (bad_status <= 10) begin
                $display("mismatch exp: rate %0d drops %0d state %0d target %0d msgs %0d a/r/t %b%b%b",
                         want.rate, want.drops, want.status, want.target, want.msgs,
                         want.alarm, want.report, want.taken);
                $display("         got: rate %0d drops %0d state %0d target %0d msgs %0d a/r/t %b%b%b pad %b",
                         got.rate, got.drops, got.status, got.target, got.msgs,
                         got.alarm, got.report, got.taken, word[79:77]);
            end
        end
    endfunction

    function int outstanding();
        return due_status.size();
    endfunction
endclass

module testbench;
    localparam logic [CFGA_W-1:0] CFG_SPARE = 2'd3;   // unmapped index
    localparam int ITEMS_PER_PHASE = 320;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [TIME_W-1:0]   s_tdata;
    logic [KIND_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFGA_W-1:0]   cfg_addr;
    logic [CFGD_W-1:0]   cfg_data;

    drip_status_tracker  tracker;
    logic [TIME_W-1:0]   t_now;
    int                  burst_left;

    drip_rate_stall_monitor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.match_status(m_tdata);
    end

    // Receiver: rotating ready pattern, reloaded now and then, plus one long hold-off
    initial begin
        int hold_left;
        int seen;
        bit held_once;
        int reload;
        logic [7:0] pat;
        hold_left = 0;
        seen = 0;
        held_once = 1'b0;
        reload = 0;
        pat = 8'hFF;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) seen++;
            if (!held_once && seen >= 150) begin
                held_once = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (reload == 0) begin
                    reload = $urandom_range(16, 96);
                    case ($urandom_range(0, 3))
                        0: pat = 8'hFF;
                        1: pat = 8'($urandom);
                        2: pat = 8'h11;
                        default: pat = 8'hB6;
                    endcase
                end
                reload--;
                pat = {pat[0], pat[7:1]};
                m_tready <= pat[0];
            end
        end
    end

    task automatic send_event(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] stamp);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= stamp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.take_event(kind, stamp);
    endtask

    task automatic idle_input(int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= KIND_W'($urandom);
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic cfg_write(logic [CFGA_W-1:0] addr, logic [CFGD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_register(addr, data);
    endtask

    task automatic configure(logic [CFGD_W-1:0] gap, logic [CFGD_W-1:0] stall,
                             logic [CFGD_W-1:0] minr);
        cfg_write(CFG_DROP_GAP, gap);
        cfg_write(CFG_STALL, stall);
        cfg_write(CFG_MIN_REP, minr);
        cfg_write(CFG_SPARE, CFGD_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Mostly plausible timelines around the gap and stall thresholds, a few wild jumps
    task automatic random_phase(int count);
        int roll;
        int g;
        int s;
        logic [KIND_W-1:0] kind;
        g = tracker.drop_gap;
        s = tracker.stall_time;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)      kind = REQ_DROP;
            else if (roll < 67) kind = REQ_CHECK;
            else if (roll < 92) kind = REQ_REPORT;
            else                kind = REQ_PRESS;
            roll = $urandom_range(0, 99);
            if (roll < 45)      t_now += $urandom_range(0, g + 3);
            else if (roll < 70) t_now += g + $urandom_range(0, 2);
            else if (roll < 88) t_now += (s > 2 ? s - 2 : 0) + $urandom_range(0, 4);
            else if (roll < 97) t_now += $urandom_range(0, 2 * s + 2 * g + 10);
            else                t_now = $urandom;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                idle_input($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
            end
            burst_left--;
            send_event(kind, t_now);
        end
    endtask

    initial begin
        tracker = new();
        burst_left = 0;
        t_now = '0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_DROP;
        cfg_valid <= 1'b0;
        cfg_addr  <= CFG_DROP_GAP;
        cfg_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset settings
        send_event(REQ_REPORT, 32'd0);           // idle: not counted
        send_event(REQ_CHECK, 32'd0);
        send_event(REQ_DROP, 32'd0);             // zero interval
        send_event(REQ_DROP, 32'd200);           // equal to gap: rejected
        send_event(REQ_DROP, 32'd201);
        send_event(REQ_PRESS, 32'd250);          // start, latches rate
        send_event(REQ_REPORT, 32'd300);
        send_event(REQ_REPORT, 32'd400);
        send_event(REQ_CHECK, 32'd5201);         // exactly the stall time
        send_event(REQ_CHECK, 32'd5202);         // blockage
        send_event(REQ_CHECK, 32'd6000);         // disarmed, re-arms
        send_event(REQ_REPORT, 32'd6100);        // blocked: not counted
        send_event(REQ_DROP, 32'hFFFF_FFFF);     // long interval, back to running
        send_event(REQ_DROP, 32'h0000_0010);     // wraps, too soon
        send_event(REQ_DROP, 32'h0000_00C9);     // wraps, accepted
        send_event(REQ_PRESS, 32'h0000_0100);    // stop
        send_event(REQ_CHECK, 32'h8000_0000);    // idle: no alarm
        send_event(REQ_PRESS, 32'h8000_0001);
        drain();

        // zero thresholds
        configure(16'd0, 16'd0, 16'd0);
        send_event(REQ_DROP, 32'h0000_00C9);
        send_event(REQ_DROP, 32'h0000_00CA);     // 1 ms: full-scale rate
        send_event(REQ_CHECK, 32'h0000_00CA);
        send_event(REQ_CHECK, 32'h0000_00CB);
        t_now = 32'h0000_00CB;

        random_phase(ITEMS_PER_PHASE);
        drain();
        configure(16'd1, 16'd1, 16'hFF00);       // upper bits of min_reports dropped
        random_phase(ITEMS_PER_PHASE);
        drain();
        configure(16'hFFFF, 16'hFFFF, 16'h00FF);
        random_phase(ITEMS_PER_PHASE);
        drain();
        configure(16'($urandom_range(1, 2000)), 16'($urandom_range(100, 20000)),
                  16'($urandom_range(0, 5)));
        random_phase(ITEMS_PER_PHASE);
        drain();
        configure(16'd50, 16'd300, 16'd3);
        random_phase(ITEMS_PER_PHASE);
        drain();
        configure(DROP_GAP_RST, STALL_RST, 16'h0101);
        random_phase(ITEMS_PER_PHASE);
        drain();

        repeat (40) @(posedge aclk);
        if (tracker.bad_status == 0 && tracker.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule
